/* sv/kfc_pkg.sv */
// ----------------------------------------------------------------------------
// kfc_pkg: shared types and constants for the keyframe clock
// Field widths, item kind codes and the phase divider interface.
// ----------------------------------------------------------------------------
package kfc_pkg;

  localparam int TIME_W  = 32;   // Q16.16 time and period values
  localparam int INDEX_W = 8;    // clip number
  localparam int LEN_W   = 10;   // keyframe count as it arrives
  localparam int FRAME_W = 9;    // reported keyframe number
  localparam int PHASE_W = 17;   // Q1.16 fraction
  localparam int KIND_W  = 2;

  localparam int MAX_KEYFRAMES_DEF = 512;

  localparam logic [PHASE_W-1:0] PHASE_MAX = '1;

  localparam logic [KIND_W-1:0] KIND_TICK    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_START   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RESERVE = 2'd2;

  typedef struct packed {
    logic              start;
    logic [TIME_W-1:0] num;
    logic [TIME_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [PHASE_W-1:0] phase;
  } div_rsp_t;

endpackage

/* sv/keyframe_clock_with_crossfade.sv */
// ----------------------------------------------------------------------------
// keyframe_clock_with_crossfade: keyframe animation clock with crossfade
// Current and reserved tracks, blend timer, three Q1.16 phases per request.
// ----------------------------------------------------------------------------
// Per request: two update steps (S_SUM, S_UPD), three phase divisions on the
//   one serial divider, shorter when the quotient saturates, and the load
//   (S_OUT), held off by out_stall. A new request waits until the load is done.
// in_stall is low whenever the sequencer is idle, even with a result waiting.
// Reset (rst, sync, active high): tracks, flags and blend timer go to their
//   reset values, loop_enable to 1, no result pending.
// ----------------------------------------------------------------------------
module keyframe_clock_with_crossfade #(
  parameter int MAX_KEYFRAMES = kfc_pkg::MAX_KEYFRAMES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // configuration
  input  logic                           cfg_wr_en,
  input  logic                           cfg_wr_data,
  // request channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [kfc_pkg::KIND_W-1:0]     kind,
  input  logic [kfc_pkg::TIME_W-1:0]     elapsed,
  input  logic [kfc_pkg::INDEX_W-1:0]    anim_index,
  input  logic [kfc_pkg::LEN_W-1:0]      frame_count,
  input  logic [kfc_pkg::TIME_W-1:0]     frame_period,
  input  logic [kfc_pkg::TIME_W-1:0]     blend_length,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [kfc_pkg::INDEX_W-1:0]    current_anim,
  output logic [kfc_pkg::FRAME_W-1:0]    current_frame,
  output logic [kfc_pkg::FRAME_W-1:0]    current_following,
  output logic [kfc_pkg::PHASE_W-1:0]    current_phase,
  output logic                           next_pending,
  output logic [kfc_pkg::INDEX_W-1:0]    next_anim,
  output logic [kfc_pkg::FRAME_W-1:0]    next_frame,
  output logic [kfc_pkg::FRAME_W-1:0]    next_following,
  output logic [kfc_pkg::PHASE_W-1:0]    next_phase,
  output logic [kfc_pkg::PHASE_W-1:0]    blend_phase,
  output logic                           sequence_end,
  output logic                           playing_now
);

  localparam int TW = kfc_pkg::TIME_W;
  localparam int IW = kfc_pkg::INDEX_W;
  localparam int LW = kfc_pkg::LEN_W;
  localparam int FW = kfc_pkg::FRAME_W;
  localparam int PW = kfc_pkg::PHASE_W;
  localparam int KW = kfc_pkg::KIND_W;

  typedef enum logic [2:0] {
    S_IDLE, S_SUM, S_UPD, S_DIV, S_WAIT, S_OUT
  } state_t;

  // phase select for the shared divider
  typedef enum logic [1:0] {
    SEL_CUR, SEL_PEND, SEL_BLEND
  } sel_t;

  state_t state;
  sel_t   sel;

  logic loop_enable;

  // latched request
  logic [KW-1:0] req_kind;
  logic [TW-1:0] req_elapsed;
  logic [IW-1:0] req_index;
  logic [LW-1:0] req_count;
  logic [TW-1:0] req_period;
  logic [TW-1:0] req_blend;

  // architectural state
  logic          is_playing, end_reached;
  logic [IW-1:0] cur_index;
  logic [LW-1:0] cur_length;
  logic [TW-1:0] cur_period, cur_elapsed;
  logic [LW-1:0] cur_frame_reg, cur_following_reg;
  logic          pend_valid;
  logic [IW-1:0] pend_index;
  logic [LW-1:0] pend_length;
  logic [TW-1:0] pend_period, pend_elapsed;
  logic [LW-1:0] pend_frame_reg, pend_following_reg;
  logic [TW-1:0] blend_elapsed, blend_total;

  // next values, applied in S_UPD
  logic          is_playing_next, end_reached_next;
  logic [IW-1:0] cur_index_next;
  logic [LW-1:0] cur_length_next;
  logic [TW-1:0] cur_period_next, cur_elapsed_next;
  logic [LW-1:0] cur_frame_next, cur_following_next;
  logic          pend_valid_next;
  logic [IW-1:0] pend_index_next;
  logic [LW-1:0] pend_length_next;
  logic [TW-1:0] pend_period_next, pend_elapsed_next;
  logic [LW-1:0] pend_frame_next, pend_following_next;
  logic [TW-1:0] blend_elapsed_next, blend_total_next;

  // S_SUM products: saturated sums and advance candidates
  logic [TW-1:0] cur_sum, pend_sum, blend_sum;
  logic [LW-1:0] cur_adv_frame, cur_adv_fol, pend_adv_frame, pend_adv_fol;
  logic          cur_end_adv, cur_end_hold;
  logic [TW-1:0] cur_sum_c, pend_sum_c, blend_sum_c;
  logic [LW-1:0] cur_adv_frame_c, cur_adv_fol_c, pend_adv_frame_c, pend_adv_fol_c;
  logic          cur_end_adv_c, cur_end_hold_c;

  // phases from the divider
  logic [PW-1:0] cur_ph, pend_ph, blend_ph;

  kfc_pkg::div_req_t div_req;
  kfc_pkg::div_rsp_t div_rsp;

  function automatic logic [TW-1:0] sat_add(input logic [TW-1:0] a, input logic [TW-1:0] b);
    logic [TW:0] s;
    begin
      s = {1'b0, a} + {1'b0, b};
      sat_add = s[TW] ? '1 : s[TW-1:0];
    end
  endfunction

  // (v + 1) mod n for v < n
  function automatic logic [LW-1:0] wrap_inc(input logic [LW-1:0] v, input logic [LW-1:0] n);
    logic [LW:0] s;
    begin
      s = {1'b0, v} + 1'b1;
      wrap_inc = (s == {1'b0, n}) ? '0 : s[LW-1:0];
    end
  endfunction

  assign in_stall = (state != S_IDLE);

  // --------------------------------------------------------------------------
  // First update cycle: accumulate time, precompute frame advance
  // --------------------------------------------------------------------------
  always_comb begin
    cur_sum_c        = sat_add(cur_elapsed, req_elapsed);
    pend_sum_c       = sat_add(pend_elapsed, req_elapsed);
    blend_sum_c      = sat_add(blend_elapsed, req_elapsed);
    cur_adv_frame_c  = wrap_inc(cur_frame_reg, cur_length);
    cur_adv_fol_c    = wrap_inc(cur_adv_frame_c, cur_length);
    cur_end_adv_c    = (wrap_inc(cur_adv_fol_c, cur_length) == '0);
    cur_end_hold_c   = (wrap_inc(cur_following_reg, cur_length) == '0);
    pend_adv_frame_c = wrap_inc(pend_frame_reg, pend_length);
    pend_adv_fol_c   = wrap_inc(pend_adv_frame_c, pend_length);
  end

  // --------------------------------------------------------------------------
  // Second update cycle: compare against period and commit the request
  // --------------------------------------------------------------------------
  logic [LW-1:0] ld_len;
  logic [LW-1:0] ld_fol;
  logic [TW-1:0] ld_period;
  logic          cur_adv, cur_end;

  always_comb begin
    // clip load with count and period clamped
    if (req_count == '0) begin
      ld_len = LW'(1);
    end else if (32'(req_count) > 32'(MAX_KEYFRAMES)) begin
      ld_len = LW'(MAX_KEYFRAMES);
    end else begin
      ld_len = req_count;
    end
    ld_fol    = (ld_len == LW'(1)) ? '0 : LW'(1);
    ld_period = (req_period == '0) ? TW'(1) : req_period;

    cur_adv = (cur_sum > cur_period);
    cur_end = cur_adv ? cur_end_adv : cur_end_hold;

    is_playing_next     = is_playing;
    end_reached_next    = end_reached;
    cur_index_next      = cur_index;
    cur_length_next     = cur_length;
    cur_period_next     = cur_period;
    cur_elapsed_next    = cur_elapsed;
    cur_frame_next      = cur_frame_reg;
    cur_following_next  = cur_following_reg;
    pend_valid_next     = pend_valid;
    pend_index_next     = pend_index;
    pend_length_next    = pend_length;
    pend_period_next    = pend_period;
    pend_elapsed_next   = pend_elapsed;
    pend_frame_next     = pend_frame_reg;
    pend_following_next = pend_following_reg;
    blend_elapsed_next  = blend_elapsed;
    blend_total_next    = blend_total;

    case (req_kind)
      kfc_pkg::KIND_START: begin
        cur_index_next     = req_index;
        cur_length_next    = ld_len;
        cur_period_next    = ld_period;
        cur_elapsed_next   = '0;
        cur_frame_next     = '0;
        cur_following_next = ld_fol;
        is_playing_next    = 1'b1;
        end_reached_next   = 1'b0;
      end
      kfc_pkg::KIND_RESERVE: begin
        pend_index_next     = req_index;
        pend_length_next    = ld_len;
        pend_period_next    = ld_period;
        pend_elapsed_next   = '0;
        pend_frame_next     = '0;
        pend_following_next = ld_fol;
        blend_total_next    = (req_blend == '0) ? TW'(1) : req_blend;
        blend_elapsed_next  = '0;
        pend_valid_next     = 1'b1;
      end
      kfc_pkg::KIND_TICK: begin
        if (is_playing) begin
          // current track
          if (cur_adv) begin
            cur_elapsed_next   = '0;
            cur_frame_next     = cur_adv_frame;
            cur_following_next = cur_adv_fol;
          end else begin
            cur_elapsed_next = cur_sum;
          end
          if (cur_end) begin
            end_reached_next = 1'b1;
            if (!loop_enable) begin
              // clamp on the last keyframe and stop
              cur_frame_next     = cur_length - 1'b1;
              cur_following_next = cur_length - 1'b1;
              is_playing_next    = 1'b0;
            end
          end
          // crossfade and reserved track
          if (pend_valid) begin
            if (blend_sum > blend_total) begin
              // promotion: reserved track as it stood replaces current
              cur_index_next      = pend_index;
              cur_length_next     = pend_length;
              cur_period_next     = pend_period;
              cur_elapsed_next    = pend_elapsed;
              cur_frame_next      = pend_frame_reg;
              cur_following_next  = pend_following_reg;
              pend_valid_next     = 1'b0;
              pend_index_next     = '0;
              pend_length_next    = LW'(1);
              pend_period_next    = TW'(1);
              pend_elapsed_next   = '0;
              pend_frame_next     = '0;
              pend_following_next = '0;
              blend_elapsed_next  = '0;
              blend_total_next    = TW'(1);
            end else begin
              blend_elapsed_next = blend_sum;
              if (pend_sum > pend_period) begin
                pend_elapsed_next   = '0;
                pend_frame_next     = pend_adv_frame;
                pend_following_next = pend_adv_fol;
              end else begin
                pend_elapsed_next = pend_sum;
              end
            end
          end
        end
      end
      default: begin
        // unused kind: state holds
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Shared phase divider: current, reserved, blend in turn
  // --------------------------------------------------------------------------
  always_comb begin
    div_req.start = (state == S_DIV);
    case (sel)
      SEL_CUR: begin
        div_req.num = cur_elapsed;
        div_req.den = cur_period;
      end
      SEL_PEND: begin
        div_req.num = pend_elapsed;
        div_req.den = pend_period;
      end
      SEL_BLEND: begin
        div_req.num = blend_elapsed;
        div_req.den = blend_total;
      end
      default: begin
        div_req.num = cur_elapsed;
        div_req.den = cur_period;
      end
    endcase
  end

  kfc_phase_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // --------------------------------------------------------------------------
  // Sequencer, state registers and result registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_IDLE;
      sel                <= SEL_CUR;
      loop_enable        <= 1'b1;
      out_valid          <= 1'b0;
      is_playing         <= 1'b0;
      end_reached        <= 1'b0;
      cur_index          <= '0;
      cur_length         <= LW'(1);
      cur_period         <= TW'(1);
      cur_elapsed        <= '0;
      cur_frame_reg      <= '0;
      cur_following_reg  <= '0;
      pend_valid         <= 1'b0;
      pend_index         <= '0;
      pend_length        <= LW'(1);
      pend_period        <= TW'(1);
      pend_elapsed       <= '0;
      pend_frame_reg     <= '0;
      pend_following_reg <= '0;
      blend_elapsed      <= '0;
      blend_total        <= TW'(1);
    end else begin
      if (cfg_wr_en) begin
        loop_enable <= cfg_wr_data;
      end
      // drained result; S_OUT reloads the register itself
      if (out_valid && !out_stall && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            req_kind    <= kind;
            req_elapsed <= elapsed;
            req_index   <= anim_index;
            req_count   <= frame_count;
            req_period  <= frame_period;
            req_blend   <= blend_length;
            state       <= S_SUM;
          end
        end
        S_SUM: begin
          cur_sum        <= cur_sum_c;
          pend_sum       <= pend_sum_c;
          blend_sum      <= blend_sum_c;
          cur_adv_frame  <= cur_adv_frame_c;
          cur_adv_fol    <= cur_adv_fol_c;
          cur_end_adv    <= cur_end_adv_c;
          cur_end_hold   <= cur_end_hold_c;
          pend_adv_frame <= pend_adv_frame_c;
          pend_adv_fol   <= pend_adv_fol_c;
          state          <= S_UPD;
        end
        S_UPD: begin
          is_playing         <= is_playing_next;
          end_reached        <= end_reached_next;
          cur_index          <= cur_index_next;
          cur_length         <= cur_length_next;
          cur_period         <= cur_period_next;
          cur_elapsed        <= cur_elapsed_next;
          cur_frame_reg      <= cur_frame_next;
          cur_following_reg  <= cur_following_next;
          pend_valid         <= pend_valid_next;
          pend_index         <= pend_index_next;
          pend_length        <= pend_length_next;
          pend_period        <= pend_period_next;
          pend_elapsed       <= pend_elapsed_next;
          pend_frame_reg     <= pend_frame_next;
          pend_following_reg <= pend_following_next;
          blend_elapsed      <= blend_elapsed_next;
          blend_total        <= blend_total_next;
          sel                <= SEL_CUR;
          state              <= S_DIV;
        end
        S_DIV: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (div_rsp.done) begin
            case (sel)
              SEL_CUR: begin
                cur_ph <= div_rsp.phase;
                sel    <= SEL_PEND;
                state  <= S_DIV;
              end
              SEL_PEND: begin
                pend_ph <= div_rsp.phase;
                sel     <= SEL_BLEND;
                state   <= S_DIV;
              end
              default: begin
                blend_ph <= div_rsp.phase;
                state    <= S_OUT;
              end
            endcase
          end
        end
        S_OUT: begin
          // load once the result register is free or being drained
          if (!out_valid || !out_stall) begin
            out_valid         <= 1'b1;
            current_anim      <= cur_index;
            current_frame     <= cur_frame_reg[FW-1:0];
            current_following <= cur_following_reg[FW-1:0];
            current_phase     <= cur_ph;
            next_pending      <= pend_valid;
            next_anim         <= pend_valid ? pend_index : '0;
            next_frame        <= pend_valid ? pend_frame_reg[FW-1:0] : '0;
            next_following    <= pend_valid ? pend_following_reg[FW-1:0] : '0;
            next_phase        <= pend_valid ? pend_ph : '0;
            blend_phase       <= pend_valid ? blend_ph : '0;
            sequence_end      <= end_reached;
            playing_now       <= is_playing;
            state             <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_out_from_seq: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_OUT))
    else $error("result appeared outside the load step");

  a_frames_in_range: assert property (@(posedge clk) disable iff (rst)
    (cur_frame_reg < cur_length) && (cur_following_reg < cur_length) &&
    (pend_frame_reg < pend_length) && (pend_following_reg < pend_length))
    else $error("keyframe index beyond clip length");

  a_no_pend_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !next_pending) |->
      (next_anim == '0) && (next_phase == '0) && (blend_phase == '0))
    else $error("reserved track fields nonzero without reservation");

  a_div_done_wait: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == S_WAIT))
    else $error("divider finished while sequencer not waiting");

endmodule

/* sv/kfc_phase_div.sv */
// ----------------------------------------------------------------------------
// kfc_phase_div: serial phase divider
// Computes min((num << 16) / den, PHASE_MAX), one quotient bit per cycle.
// ----------------------------------------------------------------------------
module kfc_phase_div (
  input  logic              clk,
  input  logic              rst,
  input  kfc_pkg::div_req_t req,
  output kfc_pkg::div_rsp_t rsp
);

  localparam int TW = kfc_pkg::TIME_W;
  localparam int PW = kfc_pkg::PHASE_W;
  localparam int CW = $clog2(PW + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [TW-1:0] rem;
  logic [TW-1:0] den_q;
  logic          nbit;
  logic [PW-1:0] quo;

  logic [TW:0] trial;
  logic [TW:0] diff;
  logic        ge;

  // shifted partial remainder; only the first step brings in a dividend bit
  assign trial = {rem, nbit};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = (trial >= {1'b0, den_q});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy  <= 1'b1;
      den_q <= req.den;
      nbit  <= req.num[0];
      rem   <= {1'b0, req.num[TW-1:1]};
      if ({1'b0, req.num[TW-1:1]} >= req.den) begin
        // num >= 2*den: quotient overflows Q1.16
        quo <= kfc_pkg::PHASE_MAX;
        cnt <= '0;
      end else begin
        quo <= '0;
        cnt <= CW'(PW);
      end
    end else if (busy) begin
      if (cnt != '0) begin
        rem  <= ge ? diff[TW-1:0] : trial[TW-1:0];
        quo  <= {quo[PW-2:0], ge};
        nbit <= 1'b0;
        cnt  <= cnt - 1'b1;
      end else begin
        busy <= 1'b0;
      end
    end
  end

  assign rsp.done  = busy && (cnt == '0);
  assign rsp.phase = quo;

endmodule

/* verif/tb_keyframe_clock_with_crossfade.sv */
// ----------------------------------------------------------------------------
// tb_keyframe_clock_with_crossfade: self-checking bench for the keyframe clock
// Directed corner requests, then episodes of start / reserve / tick requests
// with random timing on both channels. A local model of the clock predicts
// every report field, which is compared in order against the block output.
// ----------------------------------------------------------------------------
module tb_keyframe_clock_with_crossfade;

  localparam int TIME_W  = kfc_pkg::TIME_W;
  localparam int INDEX_W = kfc_pkg::INDEX_W;
  localparam int LEN_W   = kfc_pkg::LEN_W;
  localparam int FRAME_W = kfc_pkg::FRAME_W;
  localparam int PHASE_W = kfc_pkg::PHASE_W;
  localparam int KIND_W  = kfc_pkg::KIND_W;

  localparam logic [PHASE_W-1:0] PHASE_MAX    = kfc_pkg::PHASE_MAX;
  localparam logic [KIND_W-1:0]  KIND_TICK    = kfc_pkg::KIND_TICK;
  localparam logic [KIND_W-1:0]  KIND_START   = kfc_pkg::KIND_START;
  localparam logic [KIND_W-1:0]  KIND_RESERVE = kfc_pkg::KIND_RESERVE;

  localparam int MAX_FRAMES      = kfc_pkg::MAX_KEYFRAMES_DEF;
  localparam int ITEMS_PER_PHASE = 280;
  localparam int RANDOM_PHASES   = 6;
  localparam int HOLD_AFTER      = 450;   // result count that triggers the long hold
  localparam int HOLD_CYCLES     = 1500;
  localparam int DRAIN_CYCLES    = 200;   // idle margin after the last result

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  // one queued entry: a request, or a loop_enable write between phases
  typedef struct {
    bit                 is_cfg;
    bit                 loop_on;
    logic [KIND_W-1:0]  kind;
    logic [TIME_W-1:0]  dt;
    logic [INDEX_W-1:0] clip;
    logic [LEN_W-1:0]   count;
    logic [TIME_W-1:0]  period;
    logic [TIME_W-1:0]  blend;
  } clip_cmd_t;

  typedef struct {
    logic [INDEX_W-1:0] clip;
    int unsigned        len;
    logic [TIME_W-1:0]  period;
    logic [TIME_W-1:0]  acc;
    int unsigned        frame;
    int unsigned        nxt;
  } track_t;

  typedef struct packed {
    logic [INDEX_W-1:0] anim;
    logic [FRAME_W-1:0] frame;
    logic [FRAME_W-1:0] following;
    logic [PHASE_W-1:0] phase;
    logic               pending;
    logic [INDEX_W-1:0] n_anim;
    logic [FRAME_W-1:0] n_frame;
    logic [FRAME_W-1:0] n_following;
    logic [PHASE_W-1:0] n_phase;
    logic [PHASE_W-1:0] blend;
    logic               ended;
    logic               playing;
  } frame_report_t;

  // --------------------------------------------------------------------------
  // DUT hookup; every input is known from time zero
  // --------------------------------------------------------------------------
  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_wr_en = 1'b0;
  logic                cfg_wr_data = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [KIND_W-1:0]   kind = '0;
  logic [TIME_W-1:0]   elapsed = '0;
  logic [INDEX_W-1:0]  anim_index = '0;
  logic [LEN_W-1:0]    frame_count = '0;
  logic [TIME_W-1:0]   frame_period = '0;
  logic [TIME_W-1:0]   blend_length = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [INDEX_W-1:0]  current_anim;
  logic [FRAME_W-1:0]  current_frame;
  logic [FRAME_W-1:0]  current_following;
  logic [PHASE_W-1:0]  current_phase;
  logic                next_pending;
  logic [INDEX_W-1:0]  next_anim;
  logic [FRAME_W-1:0]  next_frame;
  logic [FRAME_W-1:0]  next_following;
  logic [PHASE_W-1:0]  next_phase;
  logic [PHASE_W-1:0]  blend_phase;
  logic                sequence_end;
  logic                playing_now;

  keyframe_clock_with_crossfade dut (
    .clk               (clk),
    .rst               (rst),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .kind              (kind),
    .elapsed           (elapsed),
    .anim_index        (anim_index),
    .frame_count       (frame_count),
    .frame_period      (frame_period),
    .blend_length      (blend_length),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .current_anim      (current_anim),
    .current_frame     (current_frame),
    .current_following (current_following),
    .current_phase     (current_phase),
    .next_pending      (next_pending),
    .next_anim         (next_anim),
    .next_frame        (next_frame),
    .next_following    (next_following),
    .next_phase        (next_phase),
    .blend_phase       (blend_phase),
    .sequence_end      (sequence_end),
    .playing_now       (playing_now)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  clip_cmd_t     clip_cmds[$];     // pending requests and register writes
  frame_report_t reports_due[$];   // predicted reports, oldest first
  int            n_queued = 0;
  int            errors = 0;
  int            requests_sent = 0;   // NBA only, so both sides read a stable count
  int            results_seen = 0;

  // clock model
  bit            loop_on = 1'b1;
  bit            clock_running = 1'b0;
  bit            end_seen = 1'b0;
  track_t        cur_trk;
  track_t        pend_trk;
  bit            pend_on = 1'b0;
  logic [TIME_W-1:0] blend_acc = '0;
  logic [TIME_W-1:0] blend_len = 32'd1;

  // --------------------------------------------------------------------------
  // Clock model
  // --------------------------------------------------------------------------
  function automatic track_t blank_track();
    track_t t;
    t.clip   = '0;
    t.len    = 1;
    t.period = 32'd1;
    t.acc    = '0;
    t.frame  = 0;
    t.nxt    = 0;
    return t;
  endfunction

  function automatic logic [TIME_W-1:0] sat_add(logic [TIME_W-1:0] a, logic [TIME_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_W] ? '1 : s[TIME_W-1:0];
  endfunction

  // time / period as Q1.16, truncated, saturated
  function automatic logic [PHASE_W-1:0] phase_frac(logic [TIME_W-1:0] num,
                                                   logic [TIME_W-1:0] den);
    logic [63:0] q;
    q = {16'd0, num, 16'd0} / {32'd0, den};
    return (q > 64'(PHASE_MAX)) ? PHASE_MAX : q[PHASE_W-1:0];
  endfunction

  // out-of-range count clamps to [1, MAX_FRAMES]; zero period loads as one
  function automatic track_t load_track(clip_cmd_t c);
    track_t      t;
    int unsigned n;
    n = 32'(c.count);
    if (n == 0) n = 1;
    if (n > MAX_FRAMES) n = MAX_FRAMES;
    t.clip   = c.clip;
    t.len    = n;
    t.period = (c.period == '0) ? 32'd1 : c.period;
    t.acc    = '0;
    t.frame  = 0;
    t.nxt    = 1 % n;
    return t;
  endfunction

  // strict greater-than: time equal to the period does not advance
  function automatic track_t tick_track(track_t t, logic [TIME_W-1:0] dt);
    t.acc = sat_add(t.acc, dt);
    if (t.acc > t.period) begin
      t.acc   = '0;
      t.frame = (t.frame + 1) % t.len;
      t.nxt   = (t.frame + 1) % t.len;
    end
    return t;
  endfunction

  function automatic frame_report_t advance_clock(clip_cmd_t c);
    frame_report_t r;
    case (c.kind)
      KIND_START: begin
        cur_trk       = load_track(c);
        clock_running = 1'b1;
        end_seen      = 1'b0;
      end
      KIND_RESERVE: begin
        // a new reservation replaces any pending one
        pend_trk  = load_track(c);
        blend_len = (c.blend == '0) ? 32'd1 : c.blend;
        blend_acc = '0;
        pend_on   = 1'b1;
      end
      KIND_TICK: begin
        // stopped clock freezes everything, crossfade included
        if (clock_running) begin
          cur_trk = tick_track(cur_trk, c.dt);
          if ((cur_trk.nxt + 1) % cur_trk.len == 0) begin
            end_seen = 1'b1;
            if (!loop_on) begin
              cur_trk.frame = cur_trk.len - 1;
              cur_trk.nxt   = cur_trk.frame;
              clock_running = 1'b0;
            end
          end
          if (pend_on) begin
            blend_acc = sat_add(blend_acc, c.dt);
            if (blend_acc > blend_len) begin
              // promotion: the promoted track gets no end test this tick, flags untouched
              cur_trk   = pend_trk;
              pend_trk  = blank_track();
              pend_on   = 1'b0;
              blend_acc = '0;
              blend_len = 32'd1;
            end else begin
              pend_trk = tick_track(pend_trk, c.dt);
            end
          end
        end
      end
      default: ;  // unused kind only reports state
    endcase

    r             = '0;
    r.anim        = cur_trk.clip;
    r.frame       = FRAME_W'(cur_trk.frame);
    r.following   = FRAME_W'(cur_trk.nxt);
    r.phase       = phase_frac(cur_trk.acc, cur_trk.period);
    r.pending     = pend_on;
    if (pend_on) begin
      r.n_anim      = pend_trk.clip;
      r.n_frame     = FRAME_W'(pend_trk.frame);
      r.n_following = FRAME_W'(pend_trk.nxt);
      r.n_phase     = phase_frac(pend_trk.acc, pend_trk.period);
      r.blend       = phase_frac(blend_acc, blend_len);
    end
    r.ended       = end_seen;
    r.playing     = clock_running;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic push_req(logic [KIND_W-1:0] k, logic [TIME_W-1:0] dt,
                          logic [INDEX_W-1:0] clip, logic [LEN_W-1:0] count,
                          logic [TIME_W-1:0] period, logic [TIME_W-1:0] blend);
    clip_cmd_t c;
    c.is_cfg  = 1'b0;
    c.loop_on = 1'b0;
    c.kind    = k;
    c.dt      = dt;
    c.clip    = clip;
    c.count   = count;
    c.period  = period;
    c.blend   = blend;
    clip_cmds = {clip_cmds, c};
    n_queued++;
  endtask

  task automatic push_loop(bit val);
    clip_cmd_t c;
    c         = '{default: '0};
    c.is_cfg  = 1'b1;
    c.loop_on = val;
    clip_cmds = {clip_cmds, c};
  endtask

  // time values mostly near each other so frames advance and blends promote
  function automatic logic [TIME_W-1:0] pick_time();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 32'd1;
      2:       return '1;
      3, 4:    return $urandom_range(1, 64);
      8:       return $urandom;
      9:       return $urandom_range(0, 'h40_0000);
      default: return $urandom_range(0, 'h3_0000);
    endcase
  endfunction

  // short clips so ends come often; now and then the extremes
  function automatic logic [LEN_W-1:0] pick_count();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return LEN_W'($urandom_range(0, 1023));
      2:       return LEN_W'(MAX_FRAMES);
      3:       return LEN_W'(MAX_FRAMES + 1);
      default: return LEN_W'($urandom_range(1, 6));
    endcase
  endfunction

  task automatic push_random(logic [KIND_W-1:0] k);
    push_req(k, pick_time(), INDEX_W'($urandom_range(0, 255)), pick_count(), pick_time(),
             pick_time());
  endtask

  // well-formed episode: start, maybe reserve, a run of ticks with some noise
  task automatic queue_episode();
    int n_ticks;
    int roll;
    n_ticks = $urandom_range(2, 24);
    if ($urandom_range(0, 9) != 0) push_random(KIND_START);
    else push_random(KIND_W'($urandom_range(0, 3)));
    if ($urandom_range(0, 2) == 0) push_random(KIND_RESERVE);
    repeat (n_ticks) begin
      roll = $urandom_range(0, 99);
      if (roll < 8) push_random(KIND_RESERVE);
      else if (roll < 11) push_random(KIND_UNUSED);
      else if (roll < 13) push_random(KIND_START);
      else push_random(KIND_TICK);
    end
  endtask

  // per-item wait 0..18, with occasional runs of back-to-back items
  function automatic int draw_wait(inout int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) begin
      calm_left = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 18);
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endtask

  task automatic check_report(frame_report_t w);
    check_field("current_anim",      32'(w.anim),        32'(current_anim));
    check_field("current_frame",     32'(w.frame),       32'(current_frame));
    check_field("current_following", 32'(w.following),   32'(current_following));
    check_field("current_phase",     32'(w.phase),       32'(current_phase));
    check_field("next_pending",      32'(w.pending),     32'(next_pending));
    check_field("next_anim",         32'(w.n_anim),      32'(next_anim));
    check_field("next_frame",        32'(w.n_frame),     32'(next_frame));
    check_field("next_following",    32'(w.n_following), 32'(next_following));
    check_field("next_phase",        32'(w.n_phase),     32'(next_phase));
    check_field("blend_phase",       32'(w.blend),       32'(blend_phase));
    check_field("sequence_end",      32'(w.ended),       32'(sequence_end));
    check_field("playing_now",       32'(w.playing),     32'(playing_now));
  endtask

  // --------------------------------------------------------------------------
  // Request driver. Register writes wait until every report is back.
  // --------------------------------------------------------------------------
  int        tx_gap = 0;
  int        tx_calm = 0;
  clip_cmd_t held_cmd;
  bit        take_req;
  bit        next_valid;
  bit        wr_now;

  always @(posedge clk) begin
    if (rst) begin
      in_valid      <= 1'b0;
      cfg_wr_en     <= 1'b0;
      requests_sent <= 0;
      tx_gap  = 0;
    end else begin
      wr_now   = 1'b0;
      take_req = in_valid && !in_stall;
      if (take_req) begin
        reports_due = {reports_due, advance_clock(held_cmd)};
        requests_sent <= requests_sent + 1;
        tx_gap = draw_wait(tx_calm);
      end
      // a stalled request stays up with its payload unchanged
      next_valid = in_valid && !take_req;
      if (!next_valid) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (clip_cmds.size() != 0 && clip_cmds[0].is_cfg) begin
          if (!take_req && requests_sent == results_seen) begin
            wr_now  = 1'b1;
            loop_on = clip_cmds[0].loop_on;
            cfg_wr_data <= clip_cmds[0].loop_on;
            void'(clip_cmds.pop_front());
          end
        end else if (clip_cmds.size() != 0) begin
          held_cmd   = clip_cmds.pop_front();
          next_valid = 1'b1;
          kind         <= held_cmd.kind;
          elapsed      <= held_cmd.dt;
          anim_index   <= held_cmd.clip;
          frame_count  <= held_cmd.count;
          frame_period <= held_cmd.period;
          blend_length <= held_cmd.blend;
        end
      end
      in_valid  <= next_valid;
      cfg_wr_en <= wr_now;
    end
  end

  // --------------------------------------------------------------------------
  // Report monitor. Stall per report, plus one long hold to back up the block.
  // --------------------------------------------------------------------------
  int rx_wait = 0;
  int rx_calm = 0;
  int hold_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      out_stall    <= 1'b0;
      results_seen <= 0;
      rx_wait   = 0;
      hold_left = 0;
    end else begin
      if (hold_left > 0) hold_left--;
      if (out_valid && !out_stall) begin
        if (reports_due.size() == 0) begin
          $error("report with no request outstanding");
          errors++;
        end else begin
          check_report(reports_due.pop_front());
        end
        results_seen <= results_seen + 1;
        rx_wait = draw_wait(rx_calm);
        if (results_seen + 1 == HOLD_AFTER) hold_left = HOLD_CYCLES;
      end else if (out_valid && rx_wait > 0) begin
        rx_wait--;
      end
      out_stall <= (rx_wait > 0) || (hold_left > 0);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus, reset and end of run
  // --------------------------------------------------------------------------
  initial begin
    cur_trk  = blank_track();
    pend_trk = blank_track();

    push_loop(1'b1);
    push_req(KIND_TICK, '1, 8'h00, 10'd0, '0, '0);           // stopped: ignored
    push_req(KIND_UNUSED, '1, 8'hFF, 10'h3FF, '1, '1);
    push_req(KIND_RESERVE, '0, 8'hAA, 10'd0, '0, '0);        // zeros load as one
    push_req(KIND_TICK, 32'd5, 8'h00, 10'd0, '0, '0);        // crossfade frozen
    push_req(KIND_START, '0, 8'hFF, 10'h3FF, '1, 32'd1);     // count clamps high
    push_req(KIND_TICK, '0, 8'h00, 10'd0, '0, '0);
    push_req(KIND_TICK, '1, 8'h00, 10'd0, '0, '0);           // saturate, promote
    push_req(KIND_START, '0, 8'h55, 10'd2, 32'h0001_0000, '0);
    push_req(KIND_TICK, 32'h0001_0000, 8'h00, 10'd0, '0, '0); // equal: no advance
    push_req(KIND_TICK, 32'd1, 8'h00, 10'd0, '0, '0);
    push_req(KIND_RESERVE, '0, 8'h01, 10'd512, 32'h0000_8000, '1);
    repeat (2) push_req(KIND_TICK, 32'h0001_0000, 8'h00, 10'd0, '0, '0);
    push_req(KIND_RESERVE, '0, 8'h02, 10'd3, 32'h100, 32'h0002_0000); // replace
    repeat (3) push_req(KIND_TICK, 32'h0001_0000, 8'h00, 10'd0, '0, '0);
    push_req(KIND_START, '0, 8'h10, 10'd1, 32'd1, '0);       // single frame clip
    push_req(KIND_TICK, 32'd2, 8'h00, 10'd0, '0, '0);
    push_loop(1'b0);
    push_req(KIND_START, '0, 8'h20, 10'd4, 32'h1000, '0);
    repeat (3) push_req(KIND_TICK, 32'h1001, 8'h00, 10'd0, '0, '0); // clamp, stop
    push_req(KIND_RESERVE, '0, 8'h30, 10'd513, 32'd3, 32'd1);
    push_req(KIND_TICK, 32'h1001, 8'h00, 10'd0, '0, '0);     // stopped
    push_req(KIND_START, '0, 8'h21, 10'd513, 32'd3, '0);
    push_req(KIND_TICK, 32'd4, 8'h00, 10'd0, '0, '0);        // blend promotes

    // random phases alternate looping and one-shot playback
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      int target;
      target = n_queued + ITEMS_PER_PHASE;
      push_loop(p % 2 == 0);
      while (n_queued < target) queue_episode();
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    do @(posedge clk);
    while (clip_cmds.size() != 0 || in_valid || requests_sent != results_seen);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (reports_due.size() != 0) begin
      $error("%0d reports never arrived", reports_due.size());
      errors++;
    end
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // hang guard, well past the slowest legal run
  initial begin
    #10_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
